// File: rtl/core/baro_temp_pressure_compensation_unit_assert.svh
// Assertion macros shared by the compensation unit RTL.
// Each use names a label, an antecedent and a consequent; the module
// that uses them provides i_clk and i_rst_n.
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_UNIT_ASSERT_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define BTPC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("btpc: same-cycle check failed");
`define BTPC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("btpc: next-cycle check failed");
`else
`define BTPC_ASSERT_IMP(lbl, ante, cons)
`define BTPC_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// File: rtl/core/btpc_pkg.sv
`default_nettype none
package btpc_pkg;

    localparam int UP_W       = 19;   // raw pressure after the oversampling shift
    localparam int NUM1_W     = 27;   // |mc| * 2048
    localparam int B4_W       = 17;   // b4 after the >> 15
    localparam int QDEPTH_DEF = 4;

    localparam logic signed [31:0] C_T_BIAS  = 32'sd4000;
    localparam logic signed [31:0] C_P1      = 32'sd3038;
    localparam logic signed [31:0] C_P2      = -32'sd7357;
    localparam logic signed [31:0] C_P3      = 32'sd3791;
    localparam logic        [15:0] C_UP_K    = 16'd50000;
    localparam logic signed [31:0] C_X3_OFS  = 32'sd32768;

    typedef enum logic [2:0] {
        CFG_OSS   = 3'd0,
        CFG_A1_A2 = 3'd1,
        CFG_A3_A4 = 3'd2,
        CFG_A5_A6 = 3'd3,
        CFG_B1_B2 = 3'd4,
        CFG_MC_MD = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_TZ = 2'd1,
        ST_PZ = 2'd2
    } t_status;

    typedef struct packed {
        logic        [1:0]  oss;
        logic signed [15:0] ac1;
        logic signed [15:0] ac2;
        logic signed [15:0] ac3;
        logic        [15:0] ac4;
        logic        [15:0] ac5;
        logic        [15:0] ac6;
        logic signed [15:0] b1;
        logic signed [15:0] b2;
        logic signed [15:0] mc;
        logic signed [15:0] md;
    } t_coef;

    // Queue entry: classified sample handed from front to back
    typedef struct packed {
        logic signed [31:0] x1;
        logic        [31:0] dabs;
        logic               dneg;
        logic               tz;
        logic [UP_W-1:0]    up;
    } t_qent;

    typedef struct packed {
        logic signed [31:0] x1;
        logic [UP_W-1:0]    up;
        logic               tz;
        logic               neg;
    } t_d1pay;

    typedef struct packed {
        logic signed [15:0] temp;
        logic               tz;
        logic               pz;
        logic               hi;
    } t_d2pay;

endpackage
`default_nettype wire

// File: rtl/core/btpc_front.sv
`default_nettype none
module btpc_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire btpc_pkg::t_coef i_coef,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic [15:0]   i_raw_temperature,
    input  wire logic [23:0]   i_raw_pressure,
    input  wire logic          i_q_full,
    output logic               o_q_push,
    output btpc_pkg::t_qent    o_q_data
);
    import btpc_pkg::*;

    logic                   r_v;
    logic signed [31:0]     r_x1;
    logic [UP_W-1:0]        r_up;
    logic                   accept;
    logic [16:0]            diff;
    logic signed [33:0]     prod;
    logic [23:0]            up_sh;
    logic signed [31:0]     den;

    assign o_in_ready = !r_v || !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign o_q_push   = r_v && !i_q_full;

    // x1 = ((ut - ac6) * ac5) >> 15, product wrapped to 32 bits
    assign diff  = {1'b0, i_raw_temperature} - {1'b0, i_coef.ac6};
    assign prod  = $signed(diff) * $signed({1'b0, i_coef.ac5});
    assign up_sh = i_raw_pressure >> (4'd8 - {2'b00, i_coef.oss});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (accept) begin
            r_v <= 1'b1;
        end else if (o_q_push) begin
            r_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x1 <= $signed(prod[31:0]) >>> 15;
            r_up <= up_sh[UP_W-1:0];
        end
    end

    // Classify: temperature divisor, its sign and magnitude
    assign den = r_x1 + {{16{i_coef.md[15]}}, i_coef.md};

    always_comb begin
        o_q_data.x1   = r_x1;
        o_q_data.dneg = den[31];
        o_q_data.dabs = den[31] ? (32'd0 - den) : den;
        o_q_data.tz   = (den == 32'sd0);
        o_q_data.up   = r_up;
    end
endmodule
`default_nettype wire

// File: rtl/core/btpc_queue.sv
`default_nettype none
`include "baro_temp_pressure_compensation_unit_assert.svh"
module btpc_queue #(
    parameter int DEPTH = btpc_pkg::QDEPTH_DEF,
    parameter int W     = $bits(btpc_pkg::t_qent)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire logic [W-1:0]  i_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_valid,
    output logic [W-1:0]       o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          pop_ok;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign pop_ok  = i_pop && o_valid;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop_ok) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !pop_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && pop_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    `BTPC_ASSERT_IMP(a_q_no_overflow, i_push, !o_full)
    `BTPC_ASSERT_NXT(a_q_cnt_up, i_push && !pop_ok, r_cnt == $past(r_cnt) + 1'b1)
    `BTPC_ASSERT_NXT(a_q_cnt_down, !i_push && pop_ok, r_cnt == $past(r_cnt) - 1'b1)
endmodule
`default_nettype wire

// File: rtl/core/btpc_div.sv
`default_nettype none
// Restoring divider, one quotient bit per stage, stalls with i_en.
module btpc_div #(
    parameter int NW = 32,
    parameter int DW = 32,
    parameter int PW = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    input  wire logic [PW-1:0] i_pay,
    output logic               o_valid,
    output logic [NW-1:0]      o_quo,
    output logic [PW-1:0]      o_pay
);
    logic          r_v   [NW];
    logic [DW-1:0] r_rem [NW];
    logic [NW-1:0] r_nq  [NW];
    logic [DW-1:0] r_d   [NW];
    logic [PW-1:0] r_pay [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic          v_in;
        logic [DW-1:0] rem_in;
        logic [NW-1:0] nq_in;
        logic [DW-1:0] d_in;
        logic [PW-1:0] pay_in;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          ge;

        if (k == 0) begin : g_head
            assign v_in   = i_valid;
            assign rem_in = '0;
            assign nq_in  = i_num;
            assign d_in   = i_den;
            assign pay_in = i_pay;
        end else begin : g_body
            assign v_in   = r_v[k-1];
            assign rem_in = r_rem[k-1];
            assign nq_in  = r_nq[k-1];
            assign d_in   = r_d[k-1];
            assign pay_in = r_pay[k-1];
        end

        assign trial = {rem_in, nq_in[NW-1]};
        assign diff  = trial - {1'b0, d_in};
        assign ge    = (trial >= {1'b0, d_in});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
                r_nq[k]  <= {nq_in[NW-2:0], ge};
                r_d[k]   <= d_in;
                r_pay[k] <= pay_in;
            end
        end
    end

    assign o_valid = r_v[NW-1];
    assign o_quo   = r_nq[NW-1];
    assign o_pay   = r_pay[NW-1];
endmodule
`default_nettype wire

// File: rtl/core/btpc_back.sv
`default_nettype none
module btpc_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire btpc_pkg::t_coef i_coef,
    input  wire logic            i_q_valid,
    input  wire btpc_pkg::t_qent i_q_data,
    output logic                 o_q_pop,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output logic signed [15:0]   o_temperature,
    output logic signed [31:0]   o_pressure,
    output logic [1:0]           o_status
);
    import btpc_pkg::*;

    localparam int P1W = $bits(t_d1pay);
    localparam int P2W = $bits(t_d2pay);

    logic en;
    logic r_o_v;

    // ---------------- temperature division ----------------
    logic [15:0]       mc_abs;
    t_d1pay            d1_in;
    logic [P1W-1:0]    d1_pay_v;
    logic              d1_v;
    logic [NUM1_W-1:0] d1_q;
    t_d1pay            d1_out;

    assign en      = !r_o_v || i_out_ready;
    assign o_q_pop = en;
    assign mc_abs  = i_coef.mc[15] ? (16'd0 - i_coef.mc) : i_coef.mc;

    always_comb begin
        d1_in.x1  = i_q_data.x1;
        d1_in.up  = i_q_data.up;
        d1_in.tz  = i_q_data.tz;
        d1_in.neg = i_coef.mc[15] ^ i_q_data.dneg;
    end

    btpc_div #(.NW(NUM1_W), .DW(32), .PW(P1W)) u_div_t (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_q_valid),
        .i_num   ({mc_abs, 11'd0}),
        .i_den   (i_q_data.dabs),
        .i_pay   (d1_in),
        .o_valid (d1_v),
        .o_quo   (d1_q),
        .o_pay   (d1_pay_v)
    );
    assign d1_out = t_d1pay'(d1_pay_v);

    // ---------------- stage A: signed quotient ----------------
    logic               r_a_v, r_a_tz;
    logic signed [31:0] r_a_x1, r_a_x2;
    logic [UP_W-1:0]    r_a_up;
    logic [31:0]        q1x;
    assign q1x = {{(32-NUM1_W){1'b0}}, d1_q};

    // ---------------- stage B: b5 ----------------
    logic               r_b_v, r_b_tz;
    logic signed [31:0] r_b_b5;
    logic [UP_W-1:0]    r_b_up;

    // ---------------- stage C: temperature, b6 ----------------
    logic               r_c_v, r_c_tz;
    logic signed [15:0] r_c_temp;
    logic signed [31:0] r_c_b6;
    logic [UP_W-1:0]    r_c_up;
    logic signed [31:0] t8;
    logic signed [31:0] tsh;
    logic signed [15:0] tsat;

    assign t8  = r_b_b5 + 32'sd8;
    assign tsh = t8 >>> 4;
    always_comb begin
        if (tsh > 32'sd32767) begin
            tsat = 16'sh7fff;
        end else if (tsh < -32'sd32768) begin
            tsat = 16'sh8000;
        end else begin
            tsat = tsh[15:0];
        end
    end

    // ---------------- stage D: products on b6 ----------------
    logic               r_d_v, r_d_tz;
    logic signed [15:0] r_d_temp;
    logic signed [31:0] r_d_b6sq, r_d_pac2, r_d_pac3;
    logic [UP_W-1:0]    r_d_up;
    logic signed [63:0] m_b6sq;
    logic signed [47:0] m_ac2, m_ac3;
    assign m_b6sq = r_c_b6 * r_c_b6;
    assign m_ac2  = i_coef.ac2 * r_c_b6;
    assign m_ac3  = i_coef.ac3 * r_c_b6;

    // ---------------- stage E: products on b6sq ----------------
    logic               r_e_v, r_e_tz;
    logic signed [15:0] r_e_temp;
    logic signed [31:0] r_e_pb2, r_e_pb1, r_e_pac2, r_e_pac3;
    logic [UP_W-1:0]    r_e_up;
    logic signed [47:0] m_b2, m_b1;
    assign m_b2 = i_coef.b2 * r_d_b6sq;
    assign m_b1 = i_coef.b1 * r_d_b6sq;

    // ---------------- stage F: x3 sums ----------------
    logic               r_f_v, r_f_tz;
    logic signed [15:0] r_f_temp;
    logic signed [31:0] r_f_x3a, r_f_x3b;
    logic [UP_W-1:0]    r_f_up;
    logic signed [31:0] x3b_sum;
    assign x3b_sum = (r_e_pac3 >>> 13) + (r_e_pb1 >>> 16) + 32'sd2;

    // ---------------- stage G: b3, b4 product ----------------
    logic               r_g_v, r_g_tz;
    logic signed [15:0] r_g_temp;
    logic signed [31:0] r_g_b3;
    logic [31:0]        r_g_b4p;
    logic [UP_W-1:0]    r_g_up;
    logic signed [31:0] ac1x, b3_sum, b3_sh;
    logic [31:0]        x3u;
    logic [47:0]        m_b4;
    assign ac1x   = {{16{i_coef.ac1[15]}}, i_coef.ac1};
    assign b3_sum = {ac1x[29:0], 2'b00} + r_f_x3a;
    assign b3_sh  = b3_sum << i_coef.oss;
    assign x3u    = r_f_x3b + C_X3_OFS;
    assign m_b4   = i_coef.ac4 * x3u;

    // ---------------- stage H: b7, b4 ----------------
    logic               r_h_v, r_h_tz, r_h_pz;
    logic signed [15:0] r_h_temp;
    logic [31:0]        r_h_b7;
    logic [B4_W-1:0]    r_h_b4;
    logic [31:0]        up_d;
    logic [15:0]        up_k;
    logic [47:0]        m_b7;
    logic [B4_W-1:0]    b4;
    assign b4   = r_g_b4p[31:15];
    assign up_d = {{(32-UP_W){1'b0}}, r_g_up} - r_g_b3;
    assign up_k = C_UP_K >> i_coef.oss;
    assign m_b7 = up_d * up_k;

    // ---------------- pressure division ----------------
    t_d2pay            d2_in;
    logic [P2W-1:0]    d2_pay_v;
    logic              d2_v;
    logic [31:0]       d2_q;
    t_d2pay            d2_out;

    always_comb begin
        d2_in.temp = r_h_temp;
        d2_in.tz   = r_h_tz;
        d2_in.pz   = r_h_pz;
        d2_in.hi   = r_h_b7[31];
    end

    btpc_div #(.NW(32), .DW(B4_W), .PW(P2W)) u_div_p (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_h_v),
        .i_num   (r_h_b7[31] ? r_h_b7 : {r_h_b7[30:0], 1'b0}),
        .i_den   (r_h_b4),
        .i_pay   (d2_in),
        .o_valid (d2_v),
        .o_quo   (d2_q),
        .o_pay   (d2_pay_v)
    );
    assign d2_out = t_d2pay'(d2_pay_v);

    // ---------------- stage P: p and first products ----------------
    logic               r_p_v;
    t_d2pay             r_p_pay;
    logic signed [31:0] r_p_p, r_p_sq, r_p_m2;
    logic signed [31:0] p0, ps8;
    logic signed [63:0] m_sq, m_m2;
    assign p0   = d2_out.hi ? {d2_q[30:0], 1'b0} : d2_q;
    assign ps8  = p0 >>> 8;
    assign m_sq = ps8 * ps8;
    assign m_m2 = C_P2 * p0;

    // ---------------- stage Q: x1, x2 ----------------
    logic               r_q_v;
    t_d2pay             r_q_pay;
    logic signed [31:0] r_q_p, r_q_x1, r_q_x2;
    logic signed [63:0] m_x1;
    logic signed [31:0] m_x1w;
    assign m_x1  = r_p_sq * C_P1;
    assign m_x1w = m_x1[31:0];

    // ---------------- output ----------------
    logic signed [31:0] corr, pf;
    logic signed [15:0] r_o_temp;
    logic signed [31:0] r_o_p;
    t_status            r_o_st;
    assign corr = (r_q_x1 + r_q_x2 + C_P3) >>> 4;
    assign pf   = r_q_p + corr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
            r_f_v <= 1'b0;
            r_g_v <= 1'b0;
            r_h_v <= 1'b0;
            r_p_v <= 1'b0;
            r_q_v <= 1'b0;
            r_o_v <= 1'b0;
        end else if (en) begin
            r_a_v <= d1_v;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
            r_e_v <= r_d_v;
            r_f_v <= r_e_v;
            r_g_v <= r_f_v;
            r_h_v <= r_g_v;
            r_p_v <= d2_v;
            r_q_v <= r_p_v;
            r_o_v <= r_q_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_tz   <= d1_out.tz;
            r_a_up   <= d1_out.up;
            r_a_x1   <= d1_out.x1;
            r_a_x2   <= d1_out.neg ? (32'sd0 - q1x) : q1x;

            r_b_tz   <= r_a_tz;
            r_b_up   <= r_a_up;
            r_b_b5   <= r_a_x1 + r_a_x2;

            r_c_tz   <= r_b_tz;
            r_c_up   <= r_b_up;
            r_c_temp <= tsat;
            r_c_b6   <= r_b_b5 - C_T_BIAS;

            r_d_tz   <= r_c_tz;
            r_d_up   <= r_c_up;
            r_d_temp <= r_c_temp;
            r_d_b6sq <= $signed(m_b6sq[31:0]) >>> 12;
            r_d_pac2 <= m_ac2[31:0];
            r_d_pac3 <= m_ac3[31:0];

            r_e_tz   <= r_d_tz;
            r_e_up   <= r_d_up;
            r_e_temp <= r_d_temp;
            r_e_pb2  <= m_b2[31:0];
            r_e_pb1  <= m_b1[31:0];
            r_e_pac2 <= r_d_pac2;
            r_e_pac3 <= r_d_pac3;

            r_f_tz   <= r_e_tz;
            r_f_up   <= r_e_up;
            r_f_temp <= r_e_temp;
            r_f_x3a  <= (r_e_pb2 >>> 11) + (r_e_pac2 >>> 11);
            r_f_x3b  <= x3b_sum >>> 2;

            r_g_tz   <= r_f_tz;
            r_g_up   <= r_f_up;
            r_g_temp <= r_f_temp;
            r_g_b3   <= (b3_sh + 32'sd2) >>> 2;
            r_g_b4p  <= m_b4[31:0];

            r_h_tz   <= r_g_tz;
            r_h_temp <= r_g_temp;
            r_h_b4   <= b4;
            r_h_pz   <= (b4 == '0);
            r_h_b7   <= m_b7[31:0];

            r_p_pay  <= d2_out;
            r_p_p    <= p0;
            r_p_sq   <= m_sq[31:0];
            r_p_m2   <= m_m2[31:0];

            r_q_pay  <= r_p_pay;
            r_q_p    <= r_p_p;
            r_q_x1   <= m_x1w >>> 16;
            r_q_x2   <= r_p_m2 >>> 16;

            if (r_q_pay.tz) begin
                r_o_st   <= ST_TZ;
                r_o_temp <= '0;
                r_o_p    <= '0;
            end else if (r_q_pay.pz) begin
                r_o_st   <= ST_PZ;
                r_o_temp <= '0;
                r_o_p    <= '0;
            end else begin
                r_o_st   <= ST_OK;
                r_o_temp <= r_q_pay.temp;
                r_o_p    <= pf;
            end
        end
    end

    assign o_out_valid   = r_o_v;
    assign o_temperature = r_o_temp;
    assign o_pressure    = r_o_p;
    assign o_status      = r_o_st;
endmodule
`default_nettype wire

// File: rtl/core/baro_temp_pressure_compensation_unit.sv
// Barometric temperature / pressure compensation unit.
// Input channel (i_in_valid / o_in_ready) carries one raw temperature word
// and one raw 24-bit pressure reading per transaction; the output channel
// (o_out_valid / i_out_ready) returns temperature (0.1 degC, saturated),
// pressure (Pa) and a status code (ok, temperature divisor zero, pressure
// divisor zero; on either fault both values read zero).
// Calibration words and the oversampling setting are written through
// i_cfg_we / i_cfg_idx / i_cfg_data while the unit is idle.
// Throughput: one transaction per cycle while the receiver is ready. The
// two one-bit-per-stage dividers (27 stages for temperature, 32 for
// pressure) make up most of the pipeline from input to o_out_valid.
// A front stage computes x1 and classifies the temperature divisor, then
// feeds a small queue; the back pipeline drains it. When the receiver
// stalls, the back pipeline freezes, the queue fills, and then o_in_ready
// drops. Synchronous reset empties every stage and clears the calibration
// registers to zero.
`default_nettype none
`include "baro_temp_pressure_compensation_unit_assert.svh"
module baro_temp_pressure_compensation_unit #(
    parameter int Q_DEPTH = btpc_pkg::QDEPTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [2:0]    i_cfg_idx,
    input  wire logic [31:0]   i_cfg_data,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic [15:0]   i_raw_temperature,
    input  wire logic [23:0]   i_raw_pressure,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic signed [15:0] o_temperature,
    output logic signed [31:0] o_pressure,
    output logic [1:0]         o_status
);
    import btpc_pkg::*;

    logic [1:0]  r_oss;
    logic [31:0] r_a12, r_a34, r_a56, r_b12, r_mcmd;
    t_coef       coef;

    // Calibration registers; writes to unused indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oss  <= '0;
            r_a12  <= '0;
            r_a34  <= '0;
            r_a56  <= '0;
            r_b12  <= '0;
            r_mcmd <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_OSS:   r_oss  <= i_cfg_data[1:0];
                CFG_A1_A2: r_a12  <= i_cfg_data;
                CFG_A3_A4: r_a34  <= i_cfg_data;
                CFG_A5_A6: r_a56  <= i_cfg_data;
                CFG_B1_B2: r_b12  <= i_cfg_data;
                CFG_MC_MD: r_mcmd <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Unpack the coefficient halves
    always_comb begin
        coef.oss = r_oss;
        coef.ac1 = r_a12[31:16];
        coef.ac2 = r_a12[15:0];
        coef.ac3 = r_a34[31:16];
        coef.ac4 = r_a34[15:0];
        coef.ac5 = r_a56[31:16];
        coef.ac6 = r_a56[15:0];
        coef.b1  = r_b12[31:16];
        coef.b2  = r_b12[15:0];
        coef.mc  = r_mcmd[31:16];
        coef.md  = r_mcmd[15:0];
    end

    logic   q_full, q_push, q_pop, q_valid;
    t_qent  q_wdata;
    logic [$bits(t_qent)-1:0] q_rdata;

    btpc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_coef            (coef),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_raw_temperature (i_raw_temperature),
        .i_raw_pressure    (i_raw_pressure),
        .i_q_full          (q_full),
        .o_q_push          (q_push),
        .o_q_data          (q_wdata)
    );

    btpc_queue #(.DEPTH(Q_DEPTH), .W($bits(t_qent))) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    btpc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_coef        (coef),
        .i_q_valid     (q_valid),
        .i_q_data      (t_qent'(q_rdata)),
        .o_q_pop       (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_temperature (o_temperature),
        .o_pressure    (o_pressure),
        .o_status      (o_status)
    );

    logic        out_fault, out_zero, out_stall, st_known;
    logic [49:0] out_word;
    assign out_fault = o_out_valid && (o_status != ST_OK);
    assign out_zero  = (o_temperature == 16'sd0) && (o_pressure == 32'sd0);
    assign out_stall = o_out_valid && !i_out_ready;
    assign out_word  = {o_temperature, o_pressure, o_status};
    assign st_known  = (o_status == ST_OK) || (o_status == ST_TZ) || (o_status == ST_PZ);

    // A fault result carries zero values
    `BTPC_ASSERT_IMP(a_fault_zero, out_fault, out_zero)
    // A stalled result stays valid and unchanged
    `BTPC_ASSERT_NXT(a_out_hold, out_stall, o_out_valid && $stable(out_word))
    // Only the three defined status codes appear
    `BTPC_ASSERT_IMP(a_status_known, o_out_valid, st_known)
endmodule
`default_nettype wire

// File: tb/tb_baro_temp_pressure_compensation_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Compensation math and result matching for the pressure/temperature unit.
class comp_scoreboard;
    bit [1:0]  oss;
    bit [31:0] a1a2, a3a4, a5a6, b1b2, mcmd;
    int        nerr;
    int        nchecked;

    typedef struct {
        logic signed [15:0] temp;
        logic signed [31:0] pres;
        logic [1:0]         stat;
    } comp_result_t;

    comp_result_t pending[$];

    function new();
        nerr = 0;
        nchecked = 0;
    endfunction

    function void write_reg(btpc_pkg::t_cfg_idx idx, bit [31:0] v);
        case (idx)
            btpc_pkg::CFG_OSS:   oss  = v[1:0];
            btpc_pkg::CFG_A1_A2: a1a2 = v;
            btpc_pkg::CFG_A3_A4: a3a4 = v;
            btpc_pkg::CFG_A5_A6: a5a6 = v;
            btpc_pkg::CFG_B1_B2: b1b2 = v;
            btpc_pkg::CFG_MC_MD: mcmd = v;
            default: ;
        endcase
    endfunction

    // Fixed-point compensation; all intermediates wrap at 32 bits.
    function comp_result_t compensate(bit [15:0] ut_raw, bit [23:0] up_raw);
        comp_result_t r;
        int ac1, ac2, ac3, ac5, ac6, b1, b2, mc, md, ut;
        int x1, x2, x3, den, b5, b6, b6sq, b3, t, p;
        bit [31:0] ac4, up, b4, b7, upd, num;
        ac1 = $signed(a1a2[31:16]); ac2 = $signed(a1a2[15:0]);
        ac3 = $signed(a3a4[31:16]); ac4 = {16'd0, a3a4[15:0]};
        ac5 = {16'd0, a5a6[31:16]}; ac6 = {16'd0, a5a6[15:0]};
        b1 = $signed(b1b2[31:16]);  b2 = $signed(b1b2[15:0]);
        mc = $signed(mcmd[31:16]);  md = $signed(mcmd[15:0]);
        ut = {16'd0, ut_raw};
        up = {8'd0, up_raw} >> (8 - oss);
        r.temp = 0; r.pres = 0;
        x1 = ((ut - ac6) * ac5) >>> 15;
        den = x1 + md;
        if (den == 0) begin
            r.stat = btpc_pkg::ST_TZ;
            return r;
        end
        x2 = (mc * 2048) / den;      // truncates toward zero
        b5 = x1 + x2;
        t = (b5 + 8) >>> 4;
        if (t > 32767) t = 32767;
        if (t < -32768) t = -32768;
        b6 = b5 - 4000;
        b6sq = (b6 * b6) >>> 12;
        x1 = (b2 * b6sq) >>> 11;
        x2 = (ac2 * b6) >>> 11;
        x3 = x1 + x2;
        b3 = (((ac1 * 4 + x3) << oss) + 2) >>> 2;
        x1 = (ac3 * b6) >>> 13;
        x2 = (b1 * b6sq) >>> 16;
        x3 = (x1 + x2 + 2) >>> 2;
        b4 = (ac4 * (x3 + 32'd32768)) >> 15;
        if (b4 == 0) begin
            r.stat = btpc_pkg::ST_PZ;
            return r;
        end
        upd = up - b3;
        b7 = upd * (32'd50000 >> oss);
        if (!b7[31]) begin
            num = b7 << 1;
            p = num / b4;
        end else begin
            num = b7 / b4;
            p = num << 1;
        end
        x1 = (p >>> 8) * (p >>> 8);
        x1 = (x1 * 3038) >>> 16;
        x2 = (-7357 * p) >>> 16;
        p = p + ((x1 + x2 + 3791) >>> 4);
        r.temp = t[15:0];
        r.pres = p;
        r.stat = btpc_pkg::ST_OK;
        return r;
    endfunction

    function void note_sample(bit [15:0] ut, bit [23:0] up);
        pending.push_back(compensate(ut, up));
    endfunction

    // Returns a short description of the first problem, empty when fine.
    function string check_result(logic signed [15:0] t, logic signed [31:0] p,
                                 logic [1:0] s);
        comp_result_t e;
        nchecked++;
        if (pending.size() == 0) return "result with nothing pending";
        e = pending.pop_front();
        if (s !== e.stat)
            return $sformatf("status got %0d want %0d", s, e.stat);
        if (t !== e.temp)
            return $sformatf("temperature got %0d want %0d", t, e.temp);
        if (p !== e.pres)
            return $sformatf("pressure got %0d want %0d", p, e.pres);
        return "";
    endfunction
endclass

module tb_baro_temp_pressure_compensation_unit;
    import btpc_pkg::*;

    localparam int LATENCY   = 71;
    localparam int MAX_CYC   = 400000;
    localparam int N_RANDOM  = 630;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [15:0] i_raw_temperature;
    logic [23:0] i_raw_pressure;
    logic        o_out_valid;
    logic        i_out_ready;
    logic signed [15:0] o_temperature;
    logic signed [31:0] o_pressure;
    logic [1:0]  o_status;

    comp_scoreboard sb;
    int  cyc = 0;
    int  n_sent;
    int  n_tz, n_pz, n_ok;
    bit  calm;      // no idling on either side

    baro_temp_pressure_compensation_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_raw_temperature (i_raw_temperature),
        .i_raw_pressure    (i_raw_pressure),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_temperature     (o_temperature),
        .o_pressure        (o_pressure),
        .o_status          (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic report_mismatch(string msg);
        sb.nerr++;
        $display("mismatch @%0d: %s", cyc, msg);
    endtask

    // Timeout watchdog.
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc >= MAX_CYC) begin
            $display("timeout after %0d cycles", cyc);
            $display("status: fail");
            $finish;
        end
    end

    // Output side: sample at rising edge, check every accepted transaction.
    always @(posedge i_clk) begin
        string msg;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            case (o_status)
                ST_TZ:   n_tz++;
                ST_PZ:   n_pz++;
                default: n_ok++;
            endcase
            msg = sb.check_result(o_temperature, o_pressure, o_status);
            if (msg != "") report_mismatch(msg);
        end
    end

    // Receiver stalls: random bursts, switched off in the calm phase.
    initial begin
        int k;
        i_out_ready = 1'b1;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 15) == 0) begin
                i_out_ready <= 1'b0;
                k = $urandom_range(1, 19);
                repeat (k) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    task automatic write_reg(t_cfg_idx idx, bit [31:0] v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.write_reg(idx, v);
    endtask

    task automatic load_coefs(bit [1:0] oss, bit [31:0] c1, bit [31:0] c2,
                              bit [31:0] c3, bit [31:0] c4, bit [31:0] c5);
        write_reg(CFG_OSS,   {30'd0, oss});
        write_reg(CFG_A1_A2, c1);
        write_reg(CFG_A3_A4, c2);
        write_reg(CFG_A5_A6, c3);
        write_reg(CFG_B1_B2, c4);
        write_reg(CFG_MC_MD, c5);
    endtask

    // Drive one sample; called at a falling edge, returns at a falling edge
    // with valid still high so the next sample can follow directly.
    task automatic send_sample(bit [15:0] ut, bit [23:0] up);
        int k;
        if (!calm && $urandom_range(0, 9) == 0) begin
            i_in_valid <= 1'b0;
            k = $urandom_range(1, 19);
            repeat (k) @(negedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_raw_temperature <= ut;
        i_raw_pressure    <= up;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_sample(ut, up);
        n_sent++;
        @(negedge i_clk);
    endtask

    // Idle until every expected result is back, plus pipeline latency.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 8) @(negedge i_clk);
    endtask

    // Realistic datasheet-style calibration, with random jitter half of the time.
    task automatic load_typical(bit [1:0] oss);
        load_coefs(oss,
                   {16'd408, -16'sd72},
                   {-16'sd14383, 16'd32741},
                   {16'd32757, 16'd23153},
                   {16'd6190, 16'd4},
                   {-16'sd8711, 16'd2868});
        if ($urandom_range(0, 1)) begin
            write_reg(CFG_A1_A2, {16'(7000 + $urandom_range(0, 2000)),
                                  16'(-1200 + $urandom_range(0, 400))});
            write_reg(CFG_MC_MD, {16'(-11000 + $urandom_range(0, 4000)),
                                  16'(2000 + $urandom_range(0, 1500))});
        end
    endtask

    function automatic bit [15:0] typical_ut();
        return 16'($urandom_range(20000, 32000));
    endfunction

    function automatic bit [23:0] typical_up();
        return 24'($urandom_range(9000000, 13000000));
    endfunction

    initial begin
        int phase;
        sb = new();
        n_sent = 0; n_tz = 0; n_pz = 0; n_ok = 0;
        calm = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0; i_cfg_idx = CFG_OSS; i_cfg_data = '0;
        i_in_valid = 1'b0; i_raw_temperature = '0; i_raw_pressure = '0;
        sb.write_reg(CFG_OSS, 0); sb.write_reg(CFG_A1_A2, 0);
        sb.write_reg(CFG_A3_A4, 0); sb.write_reg(CFG_A5_A6, 0);
        sb.write_reg(CFG_B1_B2, 0); sb.write_reg(CFG_MC_MD, 0);
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset coefficients: md = 0 and x1 = 0 give temperature divisor zero.
        send_sample(16'h0000, 24'h000000);
        send_sample(16'hFFFF, 24'hFFFFFF);
        drain();

        // Datasheet example calibration, field extremes, all oversampling.
        load_coefs(2'd0, {16'd408, -16'sd72}, {-16'sd14383, 16'd32741},
                   {16'd32757, 16'd23153}, {16'd6190, 16'd4},
                   {-16'sd8711, 16'd2868});
        send_sample(16'd27898, 24'd23843 << 8);
        send_sample(16'h0000, 24'h000000);
        send_sample(16'hFFFF, 24'hFFFFFF);
        send_sample(16'h5555, 24'hAAAAAA);
        send_sample(16'hAAAA, 24'h555555);
        drain();
        write_reg(CFG_OSS, 32'd3);
        send_sample(16'd27898, 24'hFFFFFF);
        send_sample(16'd27898, 24'h000000);
        send_sample(16'h8000, 24'h800000);
        drain();
        // ac4 = 0 forces pressure divisor zero.
        write_reg(CFG_A3_A4, {-16'sd14383, 16'd0});
        send_sample(16'd27898, 24'd6000000);
        drain();
        // Large ac1 with a low pressure gives b7 with top bit set (second path).
        write_reg(CFG_A3_A4, {-16'sd14383, 16'd1});
        write_reg(CFG_A1_A2, {16'h7FFF, 16'h7FFF});
        send_sample(16'd27898, 24'h000000);
        send_sample(16'd27898, 24'hFFFFFF);
        drain();
        // All-ones and extreme-signed coefficients: wrapping and saturation.
        load_coefs(2'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_sample(16'h0000, 24'hFFFFFF);
        send_sample(16'hFFFF, 24'h000000);
        drain();
        load_coefs(2'd1, 32'h8000_8000, 32'h8000_FFFF, 32'hFFFF_0000,
                   32'h8000_7FFF, 32'h7FFF_0001);
        send_sample(16'h0000, 24'h123456);
        send_sample(16'hFFFF, 24'hFEDCBA);
        send_sample(16'h0001, 24'h000001);
        drain();

        // Random phases: mostly realistic calibration, some raw noise.
        for (phase = 0; phase < 9; phase++) begin
            int n;
            if (phase % 3 == 2)
                load_coefs(2'($urandom), $urandom, $urandom, $urandom,
                           $urandom, $urandom);
            else
                load_typical(2'(phase % 4));
            if (phase == 8) calm = 1'b1;
            for (n = 0; n < N_RANDOM / 9; n++) begin
                if ($urandom_range(0, 4) == 0)
                    send_sample(16'($urandom), 24'($urandom));
                else
                    send_sample(typical_ut(), typical_up());
                // Hold the sender until everything is back once per phase.
                if (n == 20) begin
                    i_in_valid <= 1'b0;
                    while (sb.pending.size() != 0) @(negedge i_clk);
                end
            end
            drain();
        end

        $display("sent %0d samples, checked %0d results", n_sent, sb.nchecked);
        $display("ok %0d, temperature divisor zero %0d, pressure divisor zero %0d",
                 n_ok, n_tz, n_pz);
        if (sb.nerr == 0 && sb.pending.size() == 0) begin
            $display("status: pass");
        end else begin
            if (sb.pending.size() != 0)
                $display("%0d expected results never arrived", sb.pending.size());
            $display("status: fail");
        end
        $finish;
    end
endmodule

`default_nettype wire
